// ===== design/dsps_pkg.sv =====
// ----------------------------------------------------------------------------
// Damped spring particle step: shared package
// Types, constants and saturating helpers for the particle step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dsps_pkg;

  localparam int PARTICLE_COUNT = 8;
  localparam int IDX_W          = 3;
  localparam int FRAC_BITS      = 16;
  localparam int CFG_W          = 31;
  localparam int WORD_W         = 32;
  localparam int MUL_W          = 34;
  localparam int PROD_W         = 2 * MUL_W;
  localparam int SHP_W          = PROD_W - FRAC_BITS;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PARTICLE_COUNT - 1);

  localparam logic [CFG_W-1:0] SPRING_GAIN_RST = CFG_W'(1 << FRAC_BITS);
  localparam logic [CFG_W-1:0] REST_LENGTH_RST = CFG_W'(1 << FRAC_BITS);
  localparam logic [CFG_W-1:0] CUTOFF_SQ_RST   = CFG_W'(4 << FRAC_BITS);
  localparam logic [CFG_W-1:0] DAMPING_RST     = CFG_W'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic [CFG_W-1:0] TIME_STEP_RST   = CFG_W'(((1 << FRAC_BITS) + 5) / 10);

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_STEP = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [2:0] REG_SPRING_GAIN = 3'd0;
  localparam logic [2:0] REG_REST_LENGTH = 3'd1;
  localparam logic [2:0] REG_CUTOFF_SQ   = 3'd2;
  localparam logic [2:0] REG_DAMPING     = 3'd3;
  localparam logic [2:0] REG_TIME_STEP   = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD_I,
    ST_LOAD_J,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_SQRT,
    ST_SPRING,
    ST_DIVINIT,
    ST_DIV,
    ST_FORCE,
    ST_PX,
    ST_PY,
    ST_UPD_I,
    ST_UPD_J,
    ST_D_MX,
    ST_D_MY,
    ST_D_WR,
    ST_I_MX,
    ST_I_MY,
    ST_I_VW,
    ST_I_PX,
    ST_I_PY,
    ST_I_PW,
    ST_READ
  } state_t;

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [68:0] v);
    if (v > 69'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -69'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[WORD_W-1:0];
    end
  endfunction

  function automatic logic signed [WORD_W-1:0] acc_sat(
    input logic signed [WORD_W-1:0] a,
    input logic signed [SHP_W-1:0]  b,
    input logic                     sub
  );
    logic signed [68:0] ae;
    logic signed [68:0] be;
    ae = {{(69-WORD_W){a[WORD_W-1]}}, a};
    be = {{(69-SHP_W){b[SHP_W-1]}}, b};
    return sat32(sub ? ae - be : ae + be);
  endfunction

endpackage

`default_nettype wire

// ===== design/damped_spring_particle_step_unit.sv =====
// ----------------------------------------------------------------------------
// Damped spring particle step unit
// Eight 2D particles in Q16.16 with pairwise springs, damping and
// symplectic Euler integration, run by one shared multiplier under a sequencer.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// item      in         start & !busy         action, particle_index, load_*
// config    in         cfg_valid & cfg_ready cfg_index, cfg_data
// result    out        out_valid strobe      out_index, out_pos_*, out_vel_*, last
//
// A load is written from idle. A readout gives one beat per particle, one beat per cycle.
// A step runs a square root of 32 iterations and a divide of 63 iterations
// for each interacting pair, skipping them for pairs out of range, then
// applies damping and integration to every particle.
// Synchronous reset clears all particle state and loads register defaults.
// Results cannot be stalled.
`default_nettype none

module damped_spring_particle_step_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          action,
  input  wire logic [2:0]          particle_index,
  input  wire logic signed [31:0]  load_pos_x,
  input  wire logic signed [31:0]  load_pos_y,
  input  wire logic signed [31:0]  load_vel_x,
  input  wire logic signed [31:0]  load_vel_y,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [30:0]         cfg_data,
  output logic                     out_valid,
  output logic [2:0]               out_index,
  output logic signed [31:0]       out_pos_x,
  output logic signed [31:0]       out_pos_y,
  output logic signed [31:0]       out_vel_x,
  output logic signed [31:0]       out_vel_y,
  output logic                     last
);

  localparam int N  = dsps_pkg::PARTICLE_COUNT;
  localparam int IW = dsps_pkg::IDX_W;
  localparam int MW = dsps_pkg::MUL_W;
  localparam int SW = dsps_pkg::SHP_W;
  localparam int FB = dsps_pkg::FRAC_BITS;

  dsps_pkg::state_t state, state_next;

  logic [30:0] spring_gain, rest_length, cutoff_squared, damping_gain, time_step;

  logic signed [31:0] pos_x [N];
  logic signed [31:0] pos_y [N];
  logic signed [31:0] vel_x [N];
  logic signed [31:0] vel_y [N];
  logic signed [31:0] frc_x [N];
  logic signed [31:0] frc_y [N];

  logic [IW-1:0]      i_idx, j_idx, sel_idx;
  logic signed [31:0] rd_px, rd_py, rd_vx, rd_vy, rd_fx, rd_fy;

  logic signed [31:0] xi, yi;
  logic signed [32:0] dx, dy;
  logic [32:0]        ax, ay;
  logic [63:0]        s_acc, s_sum;
  logic [63:0]        sq_rem, sq_res, sq_bit, sq_try;
  logic [31:0]        dv;
  logic [32:0]        div_rem, div_sh;
  logic [62:0]        div_mag;
  logic               div_neg;
  logic [5:0]         cnt;
  logic signed [31:0] f_reg, f_sat;
  logic signed [63:0] f_full;
  logic signed [SW-1:0] tmp_a, tmp_b;

  logic signed [MW-1:0]       mul_a, mul_b;
  logic signed [2*MW-1:0]     prod;
  logic signed [2*MW-1:0]     prod_neg;
  logic signed [SW-1:0]       prod_sh;

  logic far, out_of_cut, pair_done;

  assign busy      = (state != dsps_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  assign rd_px = pos_x[sel_idx];
  assign rd_py = pos_y[sel_idx];
  assign rd_vx = vel_x[sel_idx];
  assign rd_vy = vel_y[sel_idx];
  assign rd_fx = frc_x[sel_idx];
  assign rd_fy = frc_y[sel_idx];

  assign ax = dx[32] ? 33'(-dx) : 33'(dx);
  assign ay = dy[32] ? 33'(-dy) : 33'(dy);
  assign far = ax[32] | ax[31] | ay[32] | ay[31];
  assign s_sum = s_acc + prod[63:0];
  assign out_of_cut = (s_sum[63:FB] >= {{(64-FB-31){1'b0}}, cutoff_squared});
  assign sq_try = sq_res + sq_bit;
  assign div_sh = {div_rem[31:0], div_mag[62]};
  assign prod_sh = prod[2*MW-1:FB];
  assign prod_neg = -prod;
  assign f_full = div_neg ? -$signed({1'b0, div_mag}) : $signed({1'b0, div_mag});
  assign f_sat = dsps_pkg::sat32({{5{f_full[63]}}, f_full});

  always_comb begin
    unique case (state)
      dsps_pkg::ST_IDLE:   sel_idx = particle_index;
      dsps_pkg::ST_LOAD_J,
      dsps_pkg::ST_UPD_J:  sel_idx = j_idx;
      default:             sel_idx = i_idx;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      dsps_pkg::ST_SQX: begin
        mul_a = {1'b0, ax};
        mul_b = {1'b0, ax};
      end
      dsps_pkg::ST_SQY: begin
        mul_a = {1'b0, ay};
        mul_b = {1'b0, ay};
      end
      dsps_pkg::ST_SPRING: begin
        mul_a = {3'b0, spring_gain};
        mul_b = $signed({2'b0, sq_res[31:0]}) - $signed({3'b0, rest_length});
      end
      dsps_pkg::ST_FORCE: begin
        mul_a = {{2{f_sat[31]}}, f_sat};
        mul_b = {dx[32], dx};
      end
      dsps_pkg::ST_PX: begin
        mul_a = {{2{f_reg[31]}}, f_reg};
        mul_b = {dy[32], dy};
      end
      dsps_pkg::ST_D_MX: begin
        mul_a = {3'b0, damping_gain};
        mul_b = {{2{rd_vx[31]}}, rd_vx};
      end
      dsps_pkg::ST_D_MY: begin
        mul_a = {3'b0, damping_gain};
        mul_b = {{2{rd_vy[31]}}, rd_vy};
      end
      dsps_pkg::ST_I_MX: begin
        mul_a = {{2{rd_fx[31]}}, rd_fx};
        mul_b = {3'b0, time_step};
      end
      dsps_pkg::ST_I_MY: begin
        mul_a = {{2{rd_fy[31]}}, rd_fy};
        mul_b = {3'b0, time_step};
      end
      dsps_pkg::ST_I_PX: begin
        mul_a = {{2{rd_vx[31]}}, rd_vx};
        mul_b = {3'b0, time_step};
      end
      dsps_pkg::ST_I_PY: begin
        mul_a = {{2{rd_vy[31]}}, rd_vy};
        mul_b = {3'b0, time_step};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pair_done  = 1'b0;
    unique case (state)
      dsps_pkg::ST_IDLE: begin
        if (start && action == dsps_pkg::ACT_STEP) begin
          state_next = dsps_pkg::ST_LOAD_I;
        end else if (start && action == dsps_pkg::ACT_READ) begin
          state_next = dsps_pkg::ST_READ;
        end
      end
      dsps_pkg::ST_LOAD_I:  state_next = dsps_pkg::ST_LOAD_J;
      dsps_pkg::ST_LOAD_J:  state_next = dsps_pkg::ST_SQX;
      dsps_pkg::ST_SQX: begin
        if (far) begin
          pair_done = 1'b1;
        end else begin
          state_next = dsps_pkg::ST_SQY;
        end
      end
      dsps_pkg::ST_SQY:     state_next = dsps_pkg::ST_SUM;
      dsps_pkg::ST_SUM: begin
        if (out_of_cut) begin
          pair_done = 1'b1;
        end else begin
          state_next = dsps_pkg::ST_SQRT;
        end
      end
      dsps_pkg::ST_SQRT: begin
        if (cnt == '0) begin
          state_next = dsps_pkg::ST_SPRING;
        end
      end
      dsps_pkg::ST_SPRING: begin
        if (sq_res[31:0] == '0) begin
          pair_done = 1'b1;
        end else begin
          state_next = dsps_pkg::ST_DIVINIT;
        end
      end
      dsps_pkg::ST_DIVINIT: state_next = dsps_pkg::ST_DIV;
      dsps_pkg::ST_DIV: begin
        if (cnt == '0) begin
          state_next = dsps_pkg::ST_FORCE;
        end
      end
      dsps_pkg::ST_FORCE:   state_next = dsps_pkg::ST_PX;
      dsps_pkg::ST_PX:      state_next = dsps_pkg::ST_PY;
      dsps_pkg::ST_PY:      state_next = dsps_pkg::ST_UPD_I;
      dsps_pkg::ST_UPD_I:   state_next = dsps_pkg::ST_UPD_J;
      dsps_pkg::ST_UPD_J:   pair_done = 1'b1;
      dsps_pkg::ST_D_MX:    state_next = dsps_pkg::ST_D_MY;
      dsps_pkg::ST_D_MY:    state_next = dsps_pkg::ST_D_WR;
      dsps_pkg::ST_D_WR: begin
        state_next = (i_idx == dsps_pkg::LAST_IDX) ? dsps_pkg::ST_I_MX : dsps_pkg::ST_D_MX;
      end
      dsps_pkg::ST_I_MX:    state_next = dsps_pkg::ST_I_MY;
      dsps_pkg::ST_I_MY:    state_next = dsps_pkg::ST_I_VW;
      dsps_pkg::ST_I_VW:    state_next = dsps_pkg::ST_I_PX;
      dsps_pkg::ST_I_PX:    state_next = dsps_pkg::ST_I_PY;
      dsps_pkg::ST_I_PY:    state_next = dsps_pkg::ST_I_PW;
      dsps_pkg::ST_I_PW: begin
        state_next = (i_idx == dsps_pkg::LAST_IDX) ? dsps_pkg::ST_IDLE : dsps_pkg::ST_I_MX;
      end
      dsps_pkg::ST_READ: begin
        if (i_idx == dsps_pkg::LAST_IDX) begin
          state_next = dsps_pkg::ST_IDLE;
        end
      end
      default: state_next = dsps_pkg::ST_IDLE;
    endcase
    if (pair_done) begin
      if (j_idx == dsps_pkg::LAST_IDX && i_idx == dsps_pkg::LAST_IDX - 1'b1) begin
        state_next = dsps_pkg::ST_D_MX;
      end else begin
        state_next = dsps_pkg::ST_LOAD_I;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spring_gain    <= dsps_pkg::SPRING_GAIN_RST;
      rest_length    <= dsps_pkg::REST_LENGTH_RST;
      cutoff_squared <= dsps_pkg::CUTOFF_SQ_RST;
      damping_gain   <= dsps_pkg::DAMPING_RST;
      time_step      <= dsps_pkg::TIME_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dsps_pkg::REG_SPRING_GAIN: spring_gain    <= cfg_data;
        dsps_pkg::REG_REST_LENGTH: rest_length    <= cfg_data;
        dsps_pkg::REG_CUTOFF_SQ:   cutoff_squared <= cfg_data;
        dsps_pkg::REG_DAMPING:     damping_gain   <= cfg_data;
        dsps_pkg::REG_TIME_STEP:   time_step      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) begin
        pos_x[k] <= '0;
        pos_y[k] <= '0;
        vel_x[k] <= '0;
        vel_y[k] <= '0;
        frc_x[k] <= '0;
        frc_y[k] <= '0;
      end
      i_idx     <= '0;
      j_idx     <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (pair_done) begin
        if (j_idx == dsps_pkg::LAST_IDX) begin
          if (i_idx == dsps_pkg::LAST_IDX - 1'b1) begin
            i_idx <= '0;
          end else begin
            i_idx <= i_idx + 1'b1;
            j_idx <= i_idx + IW'(2);
          end
        end else begin
          j_idx <= j_idx + 1'b1;
        end
      end
      case (state)
        dsps_pkg::ST_IDLE: begin
          if (start) begin
            i_idx <= '0;
            j_idx <= IW'(1);
            if (action == dsps_pkg::ACT_LOAD) begin
              pos_x[sel_idx] <= load_pos_x;
              pos_y[sel_idx] <= load_pos_y;
              vel_x[sel_idx] <= load_vel_x;
              vel_y[sel_idx] <= load_vel_y;
            end
          end
        end
        dsps_pkg::ST_LOAD_I: begin
          xi <= rd_px;
          yi <= rd_py;
        end
        dsps_pkg::ST_LOAD_J: begin
          dx <= $signed({xi[31], xi}) - $signed({rd_px[31], rd_px});
          dy <= $signed({yi[31], yi}) - $signed({rd_py[31], rd_py});
        end
        dsps_pkg::ST_SQY: begin
          s_acc <= prod[63:0];
        end
        dsps_pkg::ST_SUM: begin
          sq_rem <= s_sum;
          sq_res <= '0;
          sq_bit <= 64'd1 << 62;
          cnt    <= 6'd31;
        end
        dsps_pkg::ST_SQRT: begin
          if (sq_rem >= sq_try) begin
            sq_rem <= sq_rem - sq_try;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt - 1'b1;
        end
        dsps_pkg::ST_SPRING: begin
          dv <= sq_res[31:0];
        end
        dsps_pkg::ST_DIVINIT: begin
          div_neg <= prod[2*MW-1];
          div_mag <= prod[2*MW-1] ? prod_neg[62:0] : prod[62:0];
          div_rem <= '0;
          cnt     <= 6'd62;
        end
        dsps_pkg::ST_DIV: begin
          if (div_sh >= {1'b0, dv}) begin
            div_rem <= div_sh - {1'b0, dv};
            div_mag <= {div_mag[61:0], 1'b1};
          end else begin
            div_rem <= div_sh;
            div_mag <= {div_mag[61:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
        end
        dsps_pkg::ST_FORCE: begin
          f_reg <= f_sat;
        end
        dsps_pkg::ST_PX: begin
          tmp_a <= prod_sh;
        end
        dsps_pkg::ST_PY: begin
          tmp_b <= prod_sh;
        end
        dsps_pkg::ST_UPD_I: begin
          frc_x[sel_idx] <= dsps_pkg::acc_sat(rd_fx, tmp_a, 1'b1);
          frc_y[sel_idx] <= dsps_pkg::acc_sat(rd_fy, tmp_b, 1'b1);
        end
        dsps_pkg::ST_UPD_J: begin
          frc_x[sel_idx] <= dsps_pkg::acc_sat(rd_fx, tmp_a, 1'b0);
          frc_y[sel_idx] <= dsps_pkg::acc_sat(rd_fy, tmp_b, 1'b0);
        end
        dsps_pkg::ST_D_MY: begin
          tmp_a <= prod_sh;
        end
        dsps_pkg::ST_D_WR: begin
          frc_x[sel_idx] <= dsps_pkg::acc_sat(rd_fx, tmp_a, 1'b1);
          frc_y[sel_idx] <= dsps_pkg::acc_sat(rd_fy, prod_sh, 1'b1);
          i_idx <= (i_idx == dsps_pkg::LAST_IDX) ? '0 : i_idx + 1'b1;
        end
        dsps_pkg::ST_I_MY: begin
          tmp_a <= prod_sh;
        end
        dsps_pkg::ST_I_VW: begin
          vel_x[sel_idx] <= dsps_pkg::acc_sat(rd_vx, tmp_a, 1'b0);
          vel_y[sel_idx] <= dsps_pkg::acc_sat(rd_vy, prod_sh, 1'b0);
        end
        dsps_pkg::ST_I_PY: begin
          tmp_a <= prod_sh;
        end
        dsps_pkg::ST_I_PW: begin
          pos_x[sel_idx] <= dsps_pkg::acc_sat(rd_px, tmp_a, 1'b0);
          pos_y[sel_idx] <= dsps_pkg::acc_sat(rd_py, prod_sh, 1'b0);
          frc_x[sel_idx] <= '0;
          frc_y[sel_idx] <= '0;
          i_idx <= i_idx + 1'b1;
        end
        dsps_pkg::ST_READ: begin
          out_valid <= 1'b1;
          out_index <= i_idx;
          out_pos_x <= rd_px;
          out_pos_y <= rd_py;
          out_vel_x <= rd_vx;
          out_vel_y <= rd_vy;
          last      <= (i_idx == dsps_pkg::LAST_IDX);
          i_idx     <= i_idx + 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
